/* design/tcw_pkg.sv */
// shared constants, types and helpers of the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam int CELL_W    = 16;
    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int RD_ROW_W  = 5;
    localparam int RD_COL_W  = 7;
    localparam int CUR_COL_W = 7;
    localparam int CUR_ROW_W = 5;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;

    localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] FILL_FIRST = ADDR_W'(CELLS - COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

    // register indexes on the config port
    localparam logic [1:0] REG_FORE  = 2'd0;
    localparam logic [1:0] REG_BACK  = 2'd1;
    localparam logic [1:0] REG_BLINK = 2'd2;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef struct packed {
        logic [3:0] fore;
        logic [3:0] back;
        logic       blink;
    } t_cfg;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_value;
        logic [CUR_COL_W-1:0] cursor_col;
        logic [CUR_ROW_W-1:0] cursor_row;
        logic                 did_scroll;
    } t_res;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // back color top bit overlaps the blink bit
    function automatic logic [7:0] attr_byte(input t_cfg c);
        logic [7:0] a;
        a = {4'b0000, c.fore} | {c.back, 4'b0000} | {c.blink, 7'b0000000};
        return a;
    endfunction

endpackage

/* design/tcw_if.sv */
// command and result channel interfaces
`timescale 1ns / 1ps

interface tcw_cmd_if import tcw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [CHAR_W-1:0]   char_code;
    logic [RD_ROW_W-1:0] read_row;
    logic [RD_COL_W-1:0] read_col;

    modport source (output valid, operation, char_code, read_row, read_col, input ready);
    modport sink   (input valid, operation, char_code, read_row, read_col, output ready);
endinterface

interface tcw_res_if import tcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_value;
    logic [CUR_COL_W-1:0] cursor_col;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic                 did_scroll;

    modport source (output valid, cell_value, cursor_col, cursor_row, did_scroll, input ready);
    modport sink   (input valid, cell_value, cursor_col, cursor_row, did_scroll, output ready);
endinterface

/* design/tcw_cfg_regs.sv */
// apb color registers
`timescale 1ns / 1ps

module tcw_cfg_regs import tcw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [1:0] w_index;
    logic       w_wr;

    assign w_index = paddr[PADDR_W-1:2];
    assign w_wr    = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_index)
                REG_FORE:  n_cfg.fore  = pwdata[3:0];
                REG_BACK:  n_cfg.back  = pwdata[3:0];
                REG_BLINK: n_cfg.blink = pwdata[0];
                default:   n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_FORE:  prdata = {28'd0, r_cfg.fore};
            REG_BACK:  prdata = {28'd0, r_cfg.back};
            REG_BLINK: prdata = {31'd0, r_cfg.blink};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fore  <= 4'd7;
            r_cfg.back  <= 4'd0;
            r_cfg.blink <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* design/tcw_screen_ram.sv */
// screen cell store, one write port and one registered read port
`timescale 1ns / 1ps

module tcw_screen_ram import tcw_pkg::*; (
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

/* design/tcw_ctrl.sv */
// cursor, command decode and store sweeps (clear, scroll copy and fill)
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tcw_cmd_if.sink           i_cmd,
    input  t_cfg              i_cfg,
    input  logic              i_room,
    input  logic [CELL_W-1:0] i_rdata,
    output t_ram_req          o_ram,
    output logic              o_push,
    output t_res              o_res
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_COPY  = 5'b00100,
        S_FILL  = 5'b01000,
        S_CLEAR = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic              r_wr_pend, n_wr_pend;
    logic              r_rd_ok, n_rd_ok;
    logic              r_init, n_init;

    logic              w_accept;
    logic [ADDR_W-1:0] w_cur_addr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_rd_in;
    logic [7:0]        w_attr;

    assign i_cmd.ready = (r_state == S_IDLE) && i_room;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_attr      = attr_byte(i_cfg);
    assign w_cur_addr  = ADDR_W'(r_row) * COLS_A + ADDR_W'(r_col);
    assign w_rd_addr   = ADDR_W'(i_cmd.read_row) * COLS_A + ADDR_W'(i_cmd.read_col);
    assign w_rd_in     = (32'(i_cmd.read_row) < ROWS) && (32'(i_cmd.read_col) < COLUMNS);

    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_row     = r_row;
        n_idx     = r_idx;
        n_wr_addr = r_idx;
        n_wr_pend = 1'b0;
        n_rd_ok   = r_rd_ok;
        n_init    = r_init;
        o_ram     = '0;
        o_push    = 1'b0;
        o_res     = '0;

        // copy write follows its read in the next cycle
        if (r_wr_pend) begin
            o_ram.we    = 1'b1;
            o_ram.waddr = r_wr_addr;
            o_ram.wdata = i_rdata;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_op'(i_cmd.operation))
                        OP_PUT: begin
                            if (i_cmd.char_code == CHAR_CR) begin
                                n_col  = '0;
                                o_push = 1'b1;
                            end else begin
                                if (i_cmd.char_code != CHAR_LF) begin
                                    o_ram.we    = 1'b1;
                                    o_ram.waddr = w_cur_addr;
                                    o_ram.wdata = {w_attr, i_cmd.char_code};
                                end
                                if (i_cmd.char_code == CHAR_LF || r_col == LAST_COL) begin
                                    n_col = '0;
                                    if (r_row == LAST_ROW) begin
                                        n_state = S_COPY;
                                        n_idx   = '0;
                                    end else begin
                                        n_row  = r_row + 1'b1;
                                        o_push = 1'b1;
                                    end
                                end else begin
                                    n_col  = r_col + 1'b1;
                                    o_push = 1'b1;
                                end
                            end
                        end
                        OP_READ: begin
                            o_ram.re    = 1'b1;
                            o_ram.raddr = w_rd_addr;
                            n_rd_ok     = w_rd_in;
                            n_state     = S_READ;
                        end
                        OP_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_idx   = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            o_push = 1'b1;
                        end
                    endcase
                end
                o_res.cursor_col = CUR_COL_W'(32'(n_col));
                o_res.cursor_row = CUR_ROW_W'(32'(n_row));
            end
            S_READ: begin
                o_push           = 1'b1;
                o_res.cell_value = r_rd_ok ? i_rdata : '0;
                o_res.cursor_col = CUR_COL_W'(32'(r_col));
                o_res.cursor_row = CUR_ROW_W'(32'(r_row));
                n_state          = S_IDLE;
            end
            S_COPY: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = r_idx + COLS_A;
                n_wr_pend   = 1'b1;
                n_wr_addr   = r_idx;
                if (r_idx == COPY_LAST) begin
                    n_idx   = FILL_FIRST;
                    n_state = S_FILL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FILL: begin
                if (!r_wr_pend) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_idx;
                    o_ram.wdata = {w_attr, 8'h00};
                    if (r_idx == LAST_CELL) begin
                        o_push           = 1'b1;
                        o_res.cursor_col = CUR_COL_W'(32'(r_col));
                        o_res.cursor_row = CUR_ROW_W'(32'(r_row));
                        o_res.did_scroll = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_idx;
                o_ram.wdata = BLANK_CELL;
                if (r_idx == LAST_CELL) begin
                    // the pass after reset answers nobody
                    o_push  = !r_init;
                    n_init  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
                o_res.cursor_col = CUR_COL_W'(32'(r_col));
                o_res.cursor_row = CUR_ROW_W'(32'(r_row));
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_col     <= '0;
            r_row     <= '0;
            r_idx     <= '0;
            r_wr_pend <= 1'b0;
            r_init    <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_row     <= n_row;
            r_idx     <= n_idx;
            r_wr_pend <= n_wr_pend;
            r_init    <= n_init;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        r_rd_ok   <= n_rd_ok;
    end

endmodule

/* design/text_console_writer.sv */
// text console writer top level: config regs, control, cell store, result buffer
//
// 80x25 teletype text console. Commands arrive as beats on i_cmd (put char,
// read cell, clear screen); every command gives exactly one result beat on
// o_res with the cell read (zero unless a read), the cursor after the command
// and a scroll flag. Colors are to be set over the apb port only while no
// command is open; the block itself does not enforce this. A put that does
// not scroll or a carriage return answers through the result register, and
// while the result buffer has room the next command can follow on the next
// cycle. A read answers once the registered read of the cell store is back.
// A scroll moves rows up with one store read and one write per cell plus a
// last trailing copy write, then blanks the bottom row with one write per
// cell in the current attribute, then answers. A clear writes the blank cell
// to all 2000 cells, then answers. After reset the store is blanked by a
// clearing pass while i_cmd.ready stays low; apb writes are taken throughout.
// The result side has a two-beat buffer, so one command is taken while a
// finished result still waits; when the receiver stalls longer, ready drops.
`timescale 1ns / 1ps

module text_console_writer import tcw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tcw_cmd_if.sink            i_cmd,
    tcw_res_if.source          o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg              w_cfg;
    t_ram_req          w_ram;
    logic [CELL_W-1:0] w_rdata;
    logic              w_push;
    t_res              w_res;
    logic              w_pop;

    logic              r_out_valid;
    t_res              r_out;
    logic              r_skid_valid;
    t_res              r_skid;

    tcw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tcw_screen_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram),
        .o_rdata (w_rdata)
    );

    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .i_cfg   (w_cfg),
        .i_room  (!r_skid_valid),
        .i_rdata (w_rdata),
        .o_ram   (w_ram),
        .o_push  (w_push),
        .o_res   (w_res)
    );

    assign w_pop            = r_out_valid && o_res.ready;
    assign o_res.valid      = r_out_valid;
    assign o_res.cell_value = r_out.cell_value;
    assign o_res.cursor_col = r_out.cursor_col;
    assign o_res.cursor_row = r_out.cursor_row;
    assign o_res.did_scroll = r_out.did_scroll;

    // a push never meets a full skid beat: commands wait for an empty skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_push) begin
            r_skid <= w_res;
        end
    end

    a_scroll_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.did_scroll |->
            o_res.cursor_col == '0 && o_res.cursor_row == CUR_ROW_W'(ROWS - 1))
        else $error("scroll result with cursor off the bottom row start");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |->
            32'(o_res.cursor_col) < COLUMNS && 32'(o_res.cursor_row) < ROWS)
        else $error("cursor outside the screen");

    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram.we |-> 32'(w_ram.waddr) < CELLS)
        else $error("cell write beyond the store");

    a_no_same_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram.we && w_ram.re |-> w_ram.waddr != w_ram.raddr)
        else $error("read and write of one cell in the same cycle");

endmodule

/* dv/tb_text_console_writer.sv */
// testbench for the text console writer: directed and random commands checked against a predictor
`timescale 1ns / 1ps

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 9;
    localparam int PHASE_ITEMS  = 250;
    localparam int DRAIN_CYCLES = 50;
    // worst case: every item scrolls, plus longest gap and stall
    localparam longint LIMIT_CYCLES = 20_000_000;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [CHAR_W-1:0]   ch;
        logic [RD_ROW_W-1:0] row;
        logic [RD_COL_W-1:0] col;
    } console_cmd_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tcw_cmd_if cmd_if ();
    tcw_res_if res_if ();

    text_console_writer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [CELL_W-1:0] screen_mem [0:CELLS-1];
    int                cursor_c;
    int                cursor_r;
    t_cfg              console_cfg;

    console_cmd_t pending_cmds [$];
    t_res         awaited_results [$];
    int           scheduled_items;
    int           mismatch_count;
    longint       cycle_count;

    int send_pause;
    int send_calm;
    bit drain_hold;
    int recv_stall;
    int recv_calm;

    initial begin
        i_clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void blank_screen();
        int i;
        for (i = 0; i < CELLS; i++) begin
            screen_mem[i] = BLANK_CELL;
        end
    endfunction

    function automatic t_res console_step(input console_cmd_t c);
        t_res       r;
        logic [7:0] attr;
        int         i;
        attr = 8'(int'(console_cfg.fore) | (int'(console_cfg.back) << 4)
                  | (int'(console_cfg.blink) << 7));
        r = '0;
        case (c.op)
            OP_PUT: begin
                if (c.ch == CHAR_CR) begin
                    cursor_c = 0;
                end else if (c.ch == CHAR_LF) begin
                    cursor_c = 0;
                    cursor_r++;
                end else begin
                    if (cursor_r < ROWS && cursor_c < COLUMNS) begin
                        screen_mem[cursor_r * COLUMNS + cursor_c] = {attr, c.ch};
                    end
                    cursor_c++;
                    if (cursor_c >= COLUMNS) begin
                        cursor_c = 0;
                        cursor_r++;
                    end
                end
                if (cursor_r >= ROWS) begin
                    // cells move up as they are, bottom row takes the current attribute
                    for (i = 0; i < CELLS - COLUMNS; i++) begin
                        screen_mem[i] = screen_mem[i + COLUMNS];
                    end
                    for (i = CELLS - COLUMNS; i < CELLS; i++) begin
                        screen_mem[i] = {attr, 8'h00};
                    end
                    cursor_r     = ROWS - 1;
                    cursor_c     = 0;
                    r.did_scroll = 1'b1;
                end
            end
            OP_READ: begin
                if (c.row < ROWS && c.col < COLUMNS) begin
                    r.cell_value = screen_mem[int'(c.row) * COLUMNS + int'(c.col)];
                end
            end
            OP_CLEAR: begin
                blank_screen();
                cursor_c = 0;
                cursor_r = 0;
            end
            default: begin
            end
        endcase
        r.cursor_col = CUR_COL_W'(cursor_c);
        r.cursor_row = CUR_ROW_W'(cursor_r);
        return r;
    endfunction

    function automatic int draw_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        console_cmd_t next_cmd;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (send_pause > 0) begin
                send_pause--;
                cmd_if.valid <= 1'b0;
            end else if (drain_hold) begin
                cmd_if.valid <= 1'b0;
                if (awaited_results.size() == 0) begin
                    drain_hold = 1'b0;
                end
            end else if (pending_cmds.size() != 0) begin
                next_cmd = pending_cmds.pop_front();
                cmd_if.valid     <= 1'b1;
                cmd_if.operation <= next_cmd.op;
                cmd_if.char_code <= next_cmd.ch;
                cmd_if.read_row  <= next_cmd.row;
                cmd_if.read_col  <= next_cmd.col;
                if (send_calm > 0) begin
                    send_calm--;
                    send_pause = 0;
                end else begin
                    send_pause = draw_pause();
                    if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(30, 120);
                end
                drain_hold = ($urandom_range(0, 149) == 0);
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // monitor: predicts on command beats, checks result beats
    always @(posedge i_clk) begin
        console_cmd_t seen;
        t_res         want;
        if (cmd_if.valid && cmd_if.ready) begin
            seen = '{op: cmd_if.operation, ch: cmd_if.char_code,
                     row: cmd_if.read_row, col: cmd_if.read_col};
            awaited_results.push_back(console_step(seen));
        end
        if (res_if.valid && res_if.ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual cell 0x%0h", $time,
                         res_if.cell_value);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                report_field("cell_value", int'(want.cell_value), int'(res_if.cell_value));
                report_field("cursor_col", int'(want.cursor_col), int'(res_if.cursor_col));
                report_field("cursor_row", int'(want.cursor_row), int'(res_if.cursor_row));
                report_field("did_scroll", int'(want.did_scroll), int'(res_if.did_scroll));
            end
        end
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if (recv_calm > 0) begin
                recv_calm--;
            end else if ($urandom_range(0, 5) == 0) begin
                recv_stall = draw_pause();
                if ($urandom_range(0, 19) == 0) recv_calm = $urandom_range(30, 150);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void push_cmd(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                     input logic [RD_ROW_W-1:0] row,
                                     input logic [RD_COL_W-1:0] col);
        pending_cmds.push_back('{op: op, ch: ch, row: row, col: col});
        if (op != OP_UNUSED) scheduled_items++;
    endfunction

    function automatic void push_put(input logic [CHAR_W-1:0] ch);
        push_cmd(OP_PUT, ch, RD_ROW_W'($urandom_range(0, 31)),
                 RD_COL_W'($urandom_range(0, 127)));
    endfunction

    function automatic void push_read(input logic [RD_ROW_W-1:0] row,
                                      input logic [RD_COL_W-1:0] col);
        push_cmd(OP_READ, CHAR_W'($urandom_range(0, 255)), row, col);
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(0, 9) < 7) return CHAR_W'($urandom_range(32, 126));
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // reads lean on the bottom rows where scrolled text lands
    function automatic void push_random_read();
        int r;
        logic [RD_ROW_W-1:0] row;
        logic [RD_COL_W-1:0] col;
        r = $urandom_range(0, 9);
        if (r < 2) row = RD_ROW_W'($urandom_range(0, 31));
        else if (r < 6) row = RD_ROW_W'($urandom_range(ROWS - 3, ROWS - 1));
        else row = RD_ROW_W'($urandom_range(0, ROWS - 1));
        if ($urandom_range(0, 9) < 2) col = RD_COL_W'($urandom_range(0, 127));
        else col = RD_COL_W'($urandom_range(0, COLUMNS - 1));
        push_read(row, col);
    endfunction

    function automatic void fill_random_phase(input int count);
        int target;
        int kind;
        int len;
        int i;
        target = scheduled_items + count;
        while (scheduled_items < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                len = ($urandom_range(0, 4) == 0) ? COLUMNS : $urandom_range(1, 90);
                for (i = 0; i < len; i++) begin
                    push_put(pick_char());
                end
                case ($urandom_range(0, 4))
                    0, 1: push_put(CHAR_LF);
                    2: begin
                        push_put(CHAR_CR);
                        push_put(CHAR_LF);
                    end
                    3: push_put(CHAR_CR);
                    default: begin
                    end
                endcase
                len = $urandom_range(0, 3);
                for (i = 0; i < len; i++) begin
                    push_read(RD_ROW_W'($urandom_range(ROWS - 2, ROWS - 1)),
                              RD_COL_W'($urandom_range(0, COLUMNS - 1)));
                end
            end else if (kind < 45) begin
                len = $urandom_range(1, 28);
                for (i = 0; i < len; i++) begin
                    push_put(CHAR_LF);
                end
            end else if (kind < 75) begin
                len = $urandom_range(1, 8);
                for (i = 0; i < len; i++) begin
                    push_random_read();
                end
            end else if (kind < 78) begin
                push_cmd(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                         RD_ROW_W'($urandom_range(0, 31)), RD_COL_W'($urandom_range(0, 127)));
            end else begin
                push_cmd(OP_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                         RD_ROW_W'($urandom_range(0, 31)), RD_COL_W'($urandom_range(0, 127)));
            end
        end
    endfunction

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || cmd_if.valid || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    // upper data bits are random, only the register's own bits count
    task automatic set_register(input logic [1:0] idx, input logic [3:0] val);
        logic [PDATA_W-1:0] data;
        data = (idx == REG_BLINK) ? (($urandom() & ~32'h1) | {31'd0, val[0]})
                                  : (($urandom() & ~32'hF) | {28'd0, val});
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FORE:  console_cfg.fore  = val;
            REG_BACK:  console_cfg.back  = val;
            REG_BLINK: console_cfg.blink = val[0];
            default: begin
            end
        endcase
    endtask

    task automatic run_phase(input logic [3:0] fore, input logic [3:0] back, input logic blink);
        wait_idle();
        set_register(REG_FORE, fore);
        set_register(REG_BACK, back);
        set_register(REG_BLINK, {3'b000, blink});
        fill_random_phase(PHASE_ITEMS);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        cmd_if.valid     = 1'b0;
        cmd_if.operation = '0;
        cmd_if.char_code = '0;
        cmd_if.read_row  = '0;
        cmd_if.read_col  = '0;
        res_if.ready     = 1'b0;
        blank_screen();
        cursor_c        = 0;
        cursor_r        = 0;
        console_cfg     = '{fore: 4'd7, back: 4'd0, blink: 1'b0};
        scheduled_items = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        send_pause      = 0;
        send_calm       = 0;
        drain_hold      = 1'b0;
        recv_stall      = 0;
        recv_calm       = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, control chars, out-of-range reads, unused op, clear
        push_read(5'd0, 7'd0);
        push_put(8'h00);
        push_put(8'hFF);
        push_put(8'h41);
        push_read(5'd0, 7'd0);
        push_read(5'd0, 7'd1);
        push_read(5'd0, 7'd2);
        push_put(CHAR_CR);
        push_put(8'h5A);
        push_read(5'd0, 7'd0);
        push_put(CHAR_LF);
        push_read(5'd31, 7'd127);
        push_read(RD_ROW_W'(ROWS), 7'd0);
        push_read(5'd0, RD_COL_W'(COLUMNS));
        push_read(RD_ROW_W'(ROWS - 1), RD_COL_W'(COLUMNS - 1));
        push_cmd(OP_UNUSED, 8'hFF, 5'd31, 7'd127);
        push_cmd(OP_UNUSED, 8'h00, 5'd0, 7'd0);
        push_cmd(OP_CLEAR, 8'hFF, 5'd31, 7'd127);
        push_read(5'd0, 7'd0);
        push_put(CHAR_LF);
        push_put(CHAR_CR);
        push_read(5'd1, 7'd0);

        run_phase(4'd0, 4'd0, 1'b0);
        run_phase(4'd15, 4'd15, 1'b1);
        run_phase(4'd15, 4'd0, 1'b1);
        run_phase(4'd0, 4'd15, 1'b0);
        run_phase(4'd7, 4'd0, 1'b0);
        run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)));
        run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)));

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/tcw_pkg.sv
design/tcw_if.sv
design/tcw_cfg_regs.sv
design/tcw_screen_ram.sv
design/tcw_ctrl.sv
design/text_console_writer.sv
dv/tb_text_console_writer.sv
